[hw/rtl/integer_to_roman_numeral_macros.svh]
// Assertion macros shared by the checker files of the Roman numeral converter.
`ifndef INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH
`define INTEGER_TO_ROMAN_NUMERAL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define I2R_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and idle in reset.
`define I2R_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/i2r_pkg.sv]
// Types, constants and the numeral table of the Roman numeral converter.
package i2r_pkg;

    localparam int VALUE_W   = 12;
    localparam int SYMBOL_W  = 8;
    localparam int ENTRIES   = 13;
    localparam int IDX_W     = $clog2(ENTRIES);

    localparam logic [VALUE_W-1:0] MAX_VALUE = 12'd3999;

    localparam logic [SYMBOL_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYMBOL_W-1:0] CH_I    = 8'h49;
    localparam logic [SYMBOL_W-1:0] CH_V    = 8'h56;
    localparam logic [SYMBOL_W-1:0] CH_X    = 8'h58;
    localparam logic [SYMBOL_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYMBOL_W-1:0] CH_C    = 8'h43;
    localparam logic [SYMBOL_W-1:0] CH_D    = 8'h44;
    localparam logic [SYMBOL_W-1:0] CH_M    = 8'h4D;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_SECOND = 3'b100
    } state_t;

    // One row of the greedy numeral table.
    typedef struct packed {
        logic [VALUE_W-1:0]  weight;
        logic [SYMBOL_W-1:0] first;
        logic [SYMBOL_W-1:0] second;
        logic                pair;
    } entry_t;

    // Table of numeral weights, largest first; subtractive forms are letter pairs.
    function automatic entry_t table_entry(input logic [IDX_W-1:0] idx);
        entry_t e;
        unique case (idx)
            4'd0:    e = '{12'd1000, CH_M, CH_NONE, 1'b0};
            4'd1:    e = '{12'd900,  CH_C, CH_M,    1'b1};
            4'd2:    e = '{12'd500,  CH_D, CH_NONE, 1'b0};
            4'd3:    e = '{12'd400,  CH_C, CH_D,    1'b1};
            4'd4:    e = '{12'd100,  CH_C, CH_NONE, 1'b0};
            4'd5:    e = '{12'd90,   CH_X, CH_C,    1'b1};
            4'd6:    e = '{12'd50,   CH_L, CH_NONE, 1'b0};
            4'd7:    e = '{12'd40,   CH_X, CH_L,    1'b1};
            4'd8:    e = '{12'd10,   CH_X, CH_NONE, 1'b0};
            4'd9:    e = '{12'd9,    CH_I, CH_X,    1'b1};
            4'd10:   e = '{12'd5,    CH_V, CH_NONE, 1'b0};
            4'd11:   e = '{12'd4,    CH_I, CH_V,    1'b1};
            default: e = '{12'd1,    CH_I, CH_NONE, 1'b0};
        endcase
        return e;
    endfunction

endpackage

[hw/rtl/integer_to_roman_numeral.sv]
// The sequencer walks the table from the largest weight; a weight that does not fit is passed over with no letter.
// Throughput: one letter per cycle while weights fit and the receiver is ready, set by the
// single compare-and-subtract unit.
// An out-of-range value gives its error transaction in the cycle after acceptance.
// A new value is taken only once the previous numeral has been fully issued.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid.
module integer_to_roman_numeral (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] symbol
    output logic        m_tlast,   // last
    output logic        m_tuser    // [0] error
);
    import i2r_pkg::*;

    state_t               state_reg,  state_next;
    logic [VALUE_W-1:0]   rem_reg,    rem_next;
    logic [IDX_W-1:0]     idx_reg,    idx_next;
    logic                 valid_reg,  valid_next;
    logic [SYMBOL_W-1:0]  symbol_reg, symbol_next;
    logic                 last_reg,   last_next;
    logic                 error_reg,  error_next;

    logic                 out_free;
    logic                 in_accept;
    logic [VALUE_W-1:0]   in_value;
    logic                 in_bad;
    entry_t               entry;
    logic                 fits;
    logic [VALUE_W-1:0]   diff;

    // The output register may be loaded when empty or when being emptied.
    assign out_free  = !valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign in_value  = s_tdata[VALUE_W-1:0];
    assign in_bad    = (in_value == '0) || (in_value > MAX_VALUE);

    // Shared compare-and-subtract unit against the current table weight.
    assign entry = table_entry(idx_reg);
    assign fits  = rem_reg >= entry.weight;
    assign diff  = rem_reg - entry.weight;

    // Sequencer and output register loading.
    always_comb begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg && !m_tready;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        error_next  = error_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (in_bad) begin
                        valid_next  = 1'b1;
                        symbol_next = CH_NONE;
                        last_next   = 1'b1;
                        error_next  = 1'b1;
                    end else begin
                        rem_next   = in_value;
                        idx_next   = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (!fits) begin
                    idx_next = idx_reg + IDX_W'(1);
                end else if (out_free) begin
                    valid_next  = 1'b1;
                    symbol_next = entry.first;
                    error_next  = 1'b0;
                    rem_next    = diff;
                    if (entry.pair) begin
                        last_next  = 1'b0;
                        state_next = ST_SECOND;
                    end else begin
                        last_next = (diff == '0);
                        if (diff == '0) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_SECOND: begin
                if (out_free) begin
                    valid_next  = 1'b1;
                    symbol_next = entry.second;
                    error_next  = 1'b0;
                    last_next   = (rem_reg == '0);
                    idx_next    = idx_reg + IDX_W'(1);
                    state_next  = (rem_reg == '0) ? ST_IDLE : ST_RUN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        idx_reg    <= idx_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        error_reg  <= error_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = symbol_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = error_reg;

endmodule

[hw/rtl/i2r_checker.sv]
// Port-level assertions for the Roman numeral converter and their binding.
`include "integer_to_roman_numeral_macros.svh"

module i2r_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,   // [7:0] symbol
    input logic        m_tlast,   // last
    input logic        m_tuser    // [0] error
);
    import i2r_pkg::*;

    logic in_accept;
    logic in_bad;

    assign in_accept = s_tvalid && s_tready;
    assign in_bad    = (s_tdata[VALUE_W-1:0] == '0) || (s_tdata[VALUE_W-1:0] > MAX_VALUE);

    // A stalled result transaction holds its payload.
    `I2R_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result changed")
    // An error result is a single, empty, final transaction.
    `I2R_ASSERT_NOW(a_err_form, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == CH_NONE), "malformed error result")
    // An out-of-range value is answered at once with an error result.
    `I2R_ASSERT_NEXT(a_err_next, aclk, aresetn, in_accept && in_bad, m_tvalid && m_tuser, "missing error result")
    // Accepting a valid value closes the input and leaves the output empty as conversion starts.
    `I2R_ASSERT_NEXT(a_busy, aclk, aresetn, in_accept && !in_bad, !s_tready && !m_tvalid, "input reopened during conversion")

endmodule

bind integer_to_roman_numeral i2r_checker u_i2r_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

[test/integer_to_roman_numeral_checker.sv]
// Checker for the Roman numeral converter: predicts each numeral and compares the letters.
module integer_to_roman_numeral_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] symbol
    input  logic        m_tlast,   // last
    input  logic        m_tuser,   // [0] error
    output int          fail_count,
    output int          outstanding,
    output int          values_seen,
    output int          letters_seen,
    output int          rejects_seen
);
    import i2r_pkg::*;

    localparam int REPORT_CAP = 30;

    // One expected output transaction.
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } letter_t;

    letter_t expected_letters[$];

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what);
        fail_count++;
        if (fail_count <= REPORT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Works out the letters of one value, most significant digit first.
    function automatic void predict_numeral(input logic [VALUE_W-1:0] value);
        int                  v;
        int                  scale;
        int                  digit;
        logic [SYMBOL_W-1:0] one_ch;
        logic [SYMBOL_W-1:0] five_ch;
        logic [SYMBOL_W-1:0] ten_ch;
        letter_t             run[$];
        v = value;
        if (v == 0 || v > MAX_VALUE) begin
            expected_letters.push_back('{CH_NONE, 1'b1, 1'b1});
            return;
        end
        scale = 1000;
        for (int place = 3; place >= 0; place--) begin
            digit = (v / scale) % 10;
            scale = scale / 10;
            // Each decimal place has its own one, five and ten letters.
            case (place)
                3: begin
                    one_ch = CH_M; five_ch = CH_NONE; ten_ch = CH_NONE;
                end
                2: begin
                    one_ch = CH_C; five_ch = CH_D; ten_ch = CH_M;
                end
                1: begin
                    one_ch = CH_X; five_ch = CH_L; ten_ch = CH_C;
                end
                default: begin
                    one_ch = CH_I; five_ch = CH_V; ten_ch = CH_X;
                end
            endcase
            // Four and nine are written subtractively; zero writes nothing.
            if (digit == 4) begin
                run.push_back('{one_ch, 1'b0, 1'b0});
                run.push_back('{five_ch, 1'b0, 1'b0});
            end else if (digit == 9) begin
                run.push_back('{one_ch, 1'b0, 1'b0});
                run.push_back('{ten_ch, 1'b0, 1'b0});
            end else if (digit >= 5) begin
                run.push_back('{five_ch, 1'b0, 1'b0});
                repeat (digit - 5) run.push_back('{one_ch, 1'b0, 1'b0});
            end else begin
                repeat (digit) run.push_back('{one_ch, 1'b0, 1'b0});
            end
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_letters.push_back(run[i]);
    endfunction

    // Both channels are sampled at the rising edge, after the stimulus settled.
    always @(posedge aclk) begin
        letter_t want;
        if (!aresetn) begin
            expected_letters.delete();
            outstanding = 0;
        end else begin
            // A value accepted at this edge extends the expected letter stream.
            if (s_tvalid && s_tready) begin
                predict_numeral(s_tdata[VALUE_W-1:0]);
                values_seen++;
            end
            // Each output transaction is held against the oldest expected letter.
            if (m_tvalid && m_tready) begin
                if (m_tuser) begin
                    rejects_seen++;
                end else begin
                    letters_seen++;
                end
                if (expected_letters.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction, symbol %h last %b error %b",
                                              m_tdata, m_tlast, m_tuser));
                end else begin
                    want = expected_letters.pop_front();
                    if (m_tdata !== want.symbol) begin
                        report_mismatch($sformatf("symbol %h, expected %h", m_tdata, want.symbol));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch($sformatf("last %b, expected %b on symbol %h",
                                                  m_tlast, want.last, want.symbol));
                    end
                    if (m_tuser !== want.error) begin
                        report_mismatch($sformatf("error %b, expected %b on symbol %h",
                                                  m_tuser, want.error, want.symbol));
                    end
                end
            end
            outstanding = expected_letters.size();
        end
    end

endmodule

[test/integer_to_roman_numeral_tb.sv]
// Testbench top for the Roman numeral converter: clock, reset, stimulus and verdict.
module integer_to_roman_numeral_tb;
    import i2r_pkg::*;

    localparam int RANDOM_ITEMS = 96;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // Receiver back-pressure patterns.
    typedef enum int {
        RX_FLOW,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pattern_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    int          fail_count;
    int          outstanding;
    int          values_seen;
    int          letters_seen;
    int          rejects_seen;
    int          burst_left   = 0;
    int          hold_left    = 0;
    int          pattern_left = 0;
    int          cycle_count  = 0;
    bit          hold_armed   = 1'b0;
    rx_pattern_t rx_pattern   = RX_FLOW;

    // Ends of the range, every digit form, and alternating bit patterns.
    logic [VALUE_W-1:0] directed_values [24] = '{
        12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd2, 12'd3,
        12'd4, 12'd5, 12'd8, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
        12'd49, 12'd1994, 12'd2048, 12'd1365, 12'd2730, 12'd3444, 12'd1000, 12'd3000
    };

    integer_to_roman_numeral u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    integer_to_roman_numeral_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .values_seen  (values_seen),
        .letters_seen (letters_seen),
        .rejects_seen (rejects_seen)
    );

    // Free-running clock with a period of ten time units.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Cycle counter that stops a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: one long hold-off when armed, otherwise a changing stall pattern.
    always @(negedge aclk) begin
        if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                rx_pattern   = rx_pattern_t'($urandom_range(0, 3));
                pattern_left = $urandom_range(8, 60);
            end
            pattern_left--;
            case (rx_pattern)
                RX_FLOW:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    // Offers one value in bursts with random gaps and waits for its transaction.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Mostly valid values, with zero and over-range values mixed in.
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 12) begin
            return VALUE_W'($urandom_range(4000, 4095));
        end
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    // Reset, directed values, random values, then drain and verdict.
    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed_values[i]) send_value(directed_values[i]);
        hold_armed = 1'b1;
        repeat (RANDOM_ITEMS) send_value(random_value());
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Converted %0d values, %0d of them rejected as zero or over range.",
                 values_seen, rejects_seen);
        $display("Checked %0d numeral letters under bursty input and varied back-pressure.",
                 letters_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
